### rtl/urd_pkg.sv
// shared width, stage word type and the per-bit division step
package urd_pkg;

    localparam int WIDTH = 32;

    // word carried between stages
    typedef struct packed {
        logic [WIDTH-1:0] acc;   // dividend bits not yet used, quotient bits shifted in
        logic [WIDTH-1:0] rem;   // partial remainder
        logic [WIDTH-1:0] den;   // divisor
        logic             dz;    // divisor was zero
    } stage_t;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    function automatic stage_t div_step(input stage_t s);
        logic [WIDTH-1:0] shifted;
        logic [WIDTH:0]   diff;
        logic             fits;
        stage_t           r;
        shifted = {s.rem[WIDTH-2:0], s.acc[WIDTH-1]};
        diff    = {1'b0, shifted} - {1'b0, s.den};
        fits    = ~diff[WIDTH];
        r.acc   = {s.acc[WIDTH-2:0], fits};
        r.rem   = fits ? diff[WIDTH-1:0] : shifted;
        r.den   = s.den;
        r.dz    = s.dz;
        return r;
    endfunction

endpackage

### rtl/urd_if.sv
// operand and result channel interfaces
interface urd_in_if
    import urd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface urd_out_if
    import urd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

### rtl/urd_stage.sv
// one pipeline stage: a single quotient bit with its own valid and stall logic
module urd_stage
    import urd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up_word,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn_word
);

    logic   valid_reg;
    logic   valid_next;
    stage_t word_reg;
    stage_t word_next;
    logic   load;

    // stage takes a word when empty or when its word leaves this cycle
    assign up_ready = ~valid_reg | dn_ready;
    assign load     = up_valid & up_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (dn_ready)
        begin
            valid_next = 1'b0;
        end
    end

    assign word_next = div_step(up_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

### rtl/unsigned_restoring_divider.sv
// top level: pipelined unsigned restoring divider
//
// unsigned 32-bit divider built as a chain of 32 register stages, one quotient
// bit per stage, most significant first. every stage holds a shift of the
// partial remainder, one 33-bit subtract and a select, so an operand word can
// enter on every clock, provided the result side keeps taking words, and a
// result word leaves once it has passed through every stage. each stage has its
// own valid bit and stalls only when it is full and the stage after it cannot
// take its word, so bubbles close up and, while a finished result waits in the
// last stage, operands keep being accepted until the stages before it are full.
// the last stage is the output register. a zero divisor raises divide_by_zero;
// the quotient is then all ones and the remainder equals the dividend, which is
// what the plain shift-and-subtract steps give.
module unsigned_restoring_divider
    import urd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    urd_in_if.sink    operands,
    urd_out_if.source results
);

    // link k feeds stage k; link WIDTH is the last stage's output
    stage_t link_word  [0:WIDTH];
    logic   link_valid [0:WIDTH];
    logic   link_ready [0:WIDTH];

    // entry word: whole dividend to shift out, empty remainder
    assign link_word[0].acc = operands.dividend;
    assign link_word[0].rem = '0;
    assign link_word[0].den = operands.divisor;
    assign link_word[0].dz  = (operands.divisor == '0);
    assign link_valid[0]    = operands.valid;
    assign operands.ready   = link_ready[0];

    for (genvar k = 0; k < WIDTH; k++)
    begin : g_stage
        urd_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_word  (link_word[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_word  (link_word[k+1])
        );
    end

    // after all steps the accumulator holds only quotient bits
    assign results.valid          = link_valid[WIDTH];
    assign link_ready[WIDTH]      = results.ready;
    assign results.quotient       = link_word[WIDTH].acc;
    assign results.remainder      = link_word[WIDTH].rem;
    assign results.divide_by_zero = link_word[WIDTH].dz;

endmodule

### rtl/urd_checker.sv
// port-level checks for the divider, bound to the top level
module urd_checker
    import urd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] quotient,
    input logic [WIDTH-1:0] remainder,
    input logic             divide_by_zero
);

    // a result word held back stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(quotient) && $stable(remainder)
            && $stable(divide_by_zero))
        else $error("result word changed while stalled");

    // zero divisor leaves every quotient bit set
    a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> quotient == '1)
        else $error("divide by zero without all-ones quotient");

    // the pipeline only pushes back when the result side stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("operands refused with no result stall");

endmodule

bind unsigned_restoring_divider urd_checker u_urd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (operands.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .quotient       (results.quotient),
    .remainder      (results.remainder),
    .divide_by_zero (results.divide_by_zero)
);
